[sv/tbq_pkg.sv]
package tbq_pkg;

    localparam int SAMPLE_W = 8;
    localparam int ACCUM_W  = 11;
    localparam int LEVEL_W  = 8;
    localparam int HIGH_W   = 9;
    localparam int NUM_W    = 7;
    localparam int TICKS_W  = 16;
    localparam int INIT_W   = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FILTER_SHIFT = 3;
    localparam int WINDOW_SHIFT = 7;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_NUMERATOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESAMPLE_TICKS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_LEN       = 2'd2;

    localparam logic [NUM_W-1:0]   RESET_WINDOW_NUMERATOR = 7'd25;
    localparam logic [TICKS_W-1:0] RESET_RESAMPLE_TICKS   = 16'd1600;
    localparam logic [INIT_W-1:0]  RESET_WARMUP_LEN       = 8'd10;

    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        logic [LEVEL_W-1:0] baseline;
        logic [LEVEL_W-1:0] bound_low;
        logic [HIGH_W-1:0]  bound_high;
        logic [TICKS_W-1:0] quiet_count;
        logic               held;
        logic               reported;
        logic [INIT_W-1:0]  warmup_left;
    } tbq_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] filtered_level;
        logic               is_pressed;
        logic               press_event;
        logic               ready_res;
        logic [LEVEL_W-1:0] window_low;
        logic [HIGH_W-1:0]  window_high;
    } tbq_result_t;

    typedef struct packed {
        logic [HIGH_W-1:0]  high;
        logic [LEVEL_W-1:0] low;
    } tbq_window_t;

    function automatic tbq_window_t tbq_window(input logic [LEVEL_W-1:0] base,
                                               input logic [NUM_W-1:0] num);
        logic [LEVEL_W+NUM_W-1:0] prod;
        logic [LEVEL_W-1:0]       half;
        tbq_window_t              win;
        prod = base * num;
        half = prod[LEVEL_W+NUM_W-1:WINDOW_SHIFT];
        win.high = {1'b0, base} + {1'b0, half};
        win.low  = (base > half) ? (base - half) : '0;
        return win;
    endfunction

endpackage

[sv/tbq_update.sv]
module tbq_update
    import tbq_pkg::*;
(
    input  tbq_state_t          state,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [NUM_W-1:0]    window_numerator,
    input  logic [TICKS_W-1:0]  resample_ticks,
    output tbq_state_t          state_next,
    output tbq_result_t         result
);

    logic [ACCUM_W-1:0] accum_new;
    logic [LEVEL_W-1:0] level;
    logic [INIT_W-1:0]  warmup_dec;
    logic [TICKS_W-1:0] quiet_inc;
    tbq_window_t        level_win;
    tbq_window_t        warm_win;
    logic               event_hit;

    always_comb begin
        accum_new  = state.accum - {{FILTER_SHIFT{1'b0}}, state.accum[ACCUM_W-1:FILTER_SHIFT]}
                     + {{(ACCUM_W-SAMPLE_W){1'b0}}, sample};
        level      = accum_new[ACCUM_W-1:FILTER_SHIFT];
        warmup_dec = state.warmup_left - 1'b1;
        quiet_inc  = state.quiet_count + 1'b1;
        level_win  = tbq_window(level, window_numerator);
        warm_win   = level_win;
        event_hit  = 1'b0;

        state_next       = state;
        state_next.accum = accum_new;

        if (state.warmup_left != '0) begin
            state_next.baseline    = level;
            state_next.warmup_left = warmup_dec;
            if (warmup_dec == '0) begin
                state_next.bound_low  = warm_win.low;
                state_next.bound_high = warm_win.high;
            end
        end else begin
            if (level < state.bound_low) begin
                state_next.held        = 1'b1;
                state_next.baseline    = level;
                state_next.bound_low   = level_win.low;
                state_next.bound_high  = level_win.high;
                state_next.quiet_count = '0;
            end else if ({1'b0, level} > state.bound_high) begin
                state_next.held        = 1'b0;
                state_next.reported    = 1'b0;
                state_next.baseline    = level;
                state_next.bound_low   = level_win.low;
                state_next.bound_high  = level_win.high;
                state_next.quiet_count = '0;
            end else begin
                state_next.quiet_count = quiet_inc;
                if (quiet_inc >= resample_ticks) begin
                    state_next.baseline    = level;
                    state_next.bound_low   = level_win.low;
                    state_next.bound_high  = level_win.high;
                    state_next.quiet_count = '0;
                end
            end
            if (state_next.held && !state_next.reported) begin
                state_next.reported = 1'b1;
                event_hit           = 1'b1;
            end
        end

        result.filtered_level = level;
        result.is_pressed     = state_next.held;
        result.press_event    = event_hit;
        result.ready_res      = (state.warmup_left == '0);
        result.window_low     = state_next.bound_low;
        result.window_high    = state_next.bound_high;
    end

endmodule

[sv/touch_button_qualifier_core.sv]
// A request taken on the s_ channel is registered in sample_reg, then its result in
// result_reg on the m_ channel, where it holds until m_ready takes it. Throughput: one
// request per cycle while m_ready does not stall the output; the whole state update is
// one pass through the filter, window compare and 8x7 window multiply between two registers.
// Reset (aresetn low, synchronous): clears the filter and window state, loads
// the register defaults and restarts the warmup at the default sample count.
module touch_button_qualifier_core
    import tbq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_raw_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_W-1:0]    m_filtered_level,
    output logic                  m_is_pressed,
    output logic                  m_press_event,
    output logic                  m_ready_res,
    output logic [LEVEL_W-1:0]    m_window_low,
    output logic [HIGH_W-1:0]     m_window_high
);

    logic [NUM_W-1:0]    numerator_reg;
    logic [TICKS_W-1:0]  resample_reg;
    tbq_state_t          state_reg;
    tbq_state_t          state_next;
    tbq_state_t          upd_state;
    tbq_result_t         upd_result;
    tbq_result_t         result_reg;
    tbq_window_t         cfg_win;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                m_valid_reg;
    logic                advance;
    logic                fire;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    tbq_update u_update (
        .state            (state_reg),
        .sample           (sample_reg),
        .window_numerator (numerator_reg),
        .resample_ticks   (resample_reg),
        .state_next       (upd_state),
        .result           (upd_result)
    );

    always_comb begin
        cfg_win    = tbq_window(state_reg.baseline, numerator_reg);
        state_next = state_reg;
        if (fire) begin
            state_next = upd_state;
        end
        if (cfg_we && cfg_addr == REG_WARMUP_LEN && state_reg.warmup_left != '0) begin
            state_next.warmup_left = cfg_wdata[INIT_W-1:0];
            if (cfg_wdata[INIT_W-1:0] == '0) begin
                state_next.bound_low  = cfg_win.low;
                state_next.bound_high = cfg_win.high;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            numerator_reg <= RESET_WINDOW_NUMERATOR;
            resample_reg  <= RESET_RESAMPLE_TICKS;
            state_reg     <= '{warmup_left: RESET_WARMUP_LEN, default: '0};
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_WINDOW_NUMERATOR: numerator_reg <= cfg_wdata[NUM_W-1:0];
                    REG_RESAMPLE_TICKS:   resample_reg  <= cfg_wdata[TICKS_W-1:0];
                    default: ;
                endcase
            end
            state_reg <= state_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_raw_sample;
        end
        if (fire) begin
            result_reg <= upd_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_level = result_reg.filtered_level;
    assign m_is_pressed     = result_reg.is_pressed;
    assign m_press_event    = result_reg.press_event;
    assign m_ready_res      = result_reg.ready_res;
    assign m_window_low     = result_reg.window_low;
    assign m_window_high    = result_reg.window_high;

    a_fire_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("computed request did not reach the result register");

    a_event_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_press_event || (m_is_pressed && m_ready_res)))
        else $error("press event without a held, ready result");

    a_warmup_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.warmup_left != '0 |-> (!state_reg.held && !state_reg.reported))
        else $error("button state changed during warmup");

    a_window_brackets: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.warmup_left == '0 |->
            (state_reg.bound_low <= state_reg.baseline &&
             {1'b0, state_reg.baseline} <= state_reg.bound_high))
        else $error("window does not enclose the baseline");

endmodule

[tb/sv/tb_touch_button_qualifier_core.sv]
`timescale 1ns / 100ps

module tb_touch_button_qualifier_core
    import tbq_pkg::*;
();

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int GAP_PCT       = 27;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 73;
    localparam int QUIET_PHASE   = 4;
    localparam logic [SAMPLE_W-1:0] DIRECTED_LEVELS [18] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254
    };

    class press_scoreboard;
        logic [NUM_W-1:0]   numerator;
        logic [TICKS_W-1:0] resample_ticks;
        logic [INIT_W-1:0]  warmup_len;
        logic [ACCUM_W-1:0] accum;
        logic [LEVEL_W-1:0] baseline;
        logic [LEVEL_W-1:0] bound_low;
        logic [HIGH_W-1:0]  bound_high;
        logic [TICKS_W-1:0] quiet_ticks;
        bit                 held;
        bit                 reported;
        logic [INIT_W-1:0]  warmup_left;
        tbq_result_t        expected_reports[$];
        int                 failures;
        int                 samples_seen;
        int                 presses_seen;
        int                 rebaselines;

        function void clear();
            numerator      = RESET_WINDOW_NUMERATOR;
            resample_ticks = RESET_RESAMPLE_TICKS;
            warmup_len     = RESET_WARMUP_LEN;
            accum          = '0;
            baseline       = '0;
            bound_low      = '0;
            bound_high     = '0;
            quiet_ticks    = '0;
            held           = 1'b0;
            reported       = 1'b0;
            warmup_left    = RESET_WARMUP_LEN;
            expected_reports.delete();
        endfunction

        function void update_window();
            int half;
            half       = (int'(baseline) * int'(numerator)) >> WINDOW_SHIFT;
            bound_high = HIGH_W'(int'(baseline) + half);
            bound_low  = (int'(baseline) > half) ? LEVEL_W'(int'(baseline) - half) : '0;
        endfunction

        function void rebase(logic [LEVEL_W-1:0] level);
            baseline    = level;
            update_window();
            quiet_ticks = '0;
            rebaselines++;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_WINDOW_NUMERATOR: numerator = data[NUM_W-1:0];
                REG_RESAMPLE_TICKS:   resample_ticks = data[TICKS_W-1:0];
                REG_WARMUP_LEN: begin
                    warmup_len = data[INIT_W-1:0];
                    if (warmup_left != 0) begin
                        warmup_left = warmup_len;
                        if (warmup_left == 0)
                            update_window();
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            tbq_result_t        res;
            logic [LEVEL_W-1:0] level;
            accum = accum - (accum >> FILTER_SHIFT) + ACCUM_W'(raw);
            level = accum[ACCUM_W-1:FILTER_SHIFT];
            res   = '0;
            if (warmup_left != 0) begin
                baseline = level;
                warmup_left--;
                if (warmup_left == 0)
                    update_window();
            end else begin
                res.ready_res = 1'b1;
                if (level < bound_low) begin
                    held = 1'b1;
                    rebase(level);
                end else if ({1'b0, level} > bound_high) begin
                    held     = 1'b0;
                    reported = 1'b0;
                    rebase(level);
                end else begin
                    quiet_ticks++;
                    if (quiet_ticks >= resample_ticks)
                        rebase(level);
                end
                if (held && !reported) begin
                    reported          = 1'b1;
                    res.press_event   = 1'b1;
                    presses_seen++;
                end
            end
            res.filtered_level = level;
            res.is_pressed     = held;
            res.window_low     = bound_low;
            res.window_high    = bound_high;
            expected_reports.push_back(res);
            samples_seen++;
        endfunction

        function void match(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_report(tbq_result_t got);
            tbq_result_t want;
            if (expected_reports.size() == 0) begin
                $error("result arrived with no request pending");
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            match("filtered_level", 16'(want.filtered_level), 16'(got.filtered_level));
            match("is_pressed", 16'(want.is_pressed), 16'(got.is_pressed));
            match("press_event", 16'(want.press_event), 16'(got.press_event));
            match("ready_res", 16'(want.ready_res), 16'(got.ready_res));
            match("window_low", 16'(want.window_low), 16'(got.window_low));
            match("window_high", 16'(want.window_high), 16'(got.window_high));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_raw_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic [LEVEL_W-1:0]    m_filtered_level;
    logic                  m_is_pressed;
    logic                  m_press_event;
    logic                  m_ready_res;
    logic [LEVEL_W-1:0]    m_window_low;
    logic [HIGH_W-1:0]     m_window_high;

    press_scoreboard sb;
    bit              gaps_on;

    touch_button_qualifier_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_sample     (s_raw_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_level (m_filtered_level),
        .m_is_pressed     (m_is_pressed),
        .m_press_event    (m_press_event),
        .m_ready_res      (m_ready_res),
        .m_window_low     (m_window_low),
        .m_window_high    (m_window_high)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(addr, data);
    endtask

    task automatic program_regs(input int num, input int ticks, input int init);
        write_reg(REG_WINDOW_NUMERATOR, CFG_DATA_W'(num));
        write_reg(REG_RESAMPLE_TICKS, CFG_DATA_W'(ticks));
        write_reg(REG_WARMUP_LEN, CFG_DATA_W'(init));
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_sample(raw);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly steady levels with jitter so presses and releases form; some raw noise
    task automatic send_traffic(input int count);
        int sent;
        int level;
        int jitter;
        int run_len;
        int v;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                level   = int'($urandom_range(0, 255));
                jitter  = int'($urandom_range(0, 4));
                run_len = int'($urandom_range(4, 20));
                if (run_len > count - sent)
                    run_len = count - sent;
                repeat (run_len) begin
                    v = level + int'($urandom_range(0, 2 * jitter)) - jitter;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    send_sample(SAMPLE_W'(v));
                    sent++;
                end
            end else begin
                run_len = int'($urandom_range(1, 5));
                if (run_len > count - sent)
                    run_len = count - sent;
                repeat (run_len) begin
                    send_sample(SAMPLE_W'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_report({m_filtered_level, m_is_pressed, m_press_event,
                                 m_ready_res, m_window_low, m_window_high});
            m_ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL touch_button_qualifier_core");
        $finish;
    end

    initial begin
        int num;
        int ticks;
        int init;
        sb = new;
        sb.clear();
        gaps_on      = 1'b1;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_raw_sample <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // write spare, zero num/ticks, shorten warmup as it runs, end it early
        write_reg(REG_SPARE, '1);
        write_reg(REG_WINDOW_NUMERATOR, '0);
        write_reg(REG_RESAMPLE_TICKS, '0);
        write_reg(REG_WARMUP_LEN, CFG_DATA_W'(4));
        cfg_we <= 1'b0;
        send_sample(8'd255);
        send_sample(8'd0);
        drain();
        write_reg(REG_WARMUP_LEN, '0);
        cfg_we <= 1'b0;
        foreach (DIRECTED_LEVELS[i])
            send_sample(DIRECTED_LEVELS[i]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin num = 127; ticks = 65535; init = 255; end
                1: begin num = 0;   ticks = 1;     init = 1;   end
                2: begin
                    num   = int'(RESET_WINDOW_NUMERATOR);
                    ticks = int'(RESET_RESAMPLE_TICKS);
                    init  = int'(RESET_WARMUP_LEN);
                end
                3: begin num = 64;  ticks = 0;     init = 3;   end
                default: begin
                    num   = int'($urandom_range(0, 127));
                    ticks = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                        : int'($urandom_range(0, 40));
                    init  = int'($urandom_range(0, 255));
                end
            endcase
            program_regs(num, ticks, init);
            gaps_on = (p != QUIET_PHASE);
            send_traffic(PHASE_ITEMS);
            drain();
        end
        gaps_on = 1'b1;

        $display("Checked %0d filtered samples over %0d register settings,", sb.samples_seen,
                 PHASES + 2);
        $display("with %0d press reports and %0d baseline refreshes.", sb.presses_seen,
                 sb.rebaselines);
        if (sb.failures == 0 && sb.expected_reports.size() == 0)
            $display("PASS touch_button_qualifier_core");
        else
            $display("FAIL touch_button_qualifier_core");
        $finish;
    end

endmodule

[touch_button_qualifier_core.f]
sv/tbq_pkg.sv
sv/tbq_update.sv
sv/touch_button_qualifier_core.sv
tb/sv/tb_touch_button_qualifier_core.sv
